// File: design/pgsjt_pkg.sv
package pgsjt_pkg;

    localparam int MAX_ELEMS   = 8;
    localparam int VALUE_WIDTH = 16;

    localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMS + 1);
    localparam int POS_W = 3;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EMIT  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        logic clear;
        logic load;
        logic exhaust;
        logic sort_step;
        logic emit_init;
        logic emit_step;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic done;
        logic emit_last;
        logic sort_last;
        logic fin;
    } t_status;

endpackage

// File: design/permutation_generator_sjt_unit.sv
// channel   direction  handshake                       payload
// command   in         start & !busy                   i_func, i_value
// result    out        o_strobe (one cycle, no stall)  o_element, o_position,
//                                                      o_last_of_perm, o_final_perm,
//                                                      o_exhausted
//
// Clear and ignored loads stay in idle; a load writes the value, then runs the
// odd-even transposition sort that re-sorts the store one pass per cycle.
// An emit runs the mobile scan, giving one result per cycle, then a swap-and-flip
// step that the final permutation skips.
// An exhausted emit gives its single result in the cycle after the item.
// Synchronous active-low reset clears count, directions and done; busy is low after it.
module permutation_generator_sjt_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [pgsjt_pkg::FUNC_W-1:0]     i_func,
    input  pgsjt_pkg::t_value                i_value,
    output logic                             o_strobe,
    output pgsjt_pkg::t_value                o_element,
    output logic [pgsjt_pkg::POS_W-1:0]      o_position,
    output logic                             o_last_of_perm,
    output logic                             o_final_perm,
    output logic                             o_exhausted
);

    pgsjt_pkg::t_cmd    cmd;
    pgsjt_pkg::t_status sts;

    pgsjt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    pgsjt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .o_sts          (sts),
        .o_strobe       (o_strobe),
        .o_element      (o_element),
        .o_position     (o_position),
        .o_last_of_perm (o_last_of_perm),
        .o_final_perm   (o_final_perm),
        .o_exhausted    (o_exhausted)
    );

endmodule

// File: design/pgsjt_ctrl.sv
module pgsjt_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [pgsjt_pkg::FUNC_W-1:0]     i_func,
    input  pgsjt_pkg::t_status               i_sts,
    output pgsjt_pkg::t_cmd                  o_cmd,
    output logic                             busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SORT   = 4'b0010,
        S_EMIT   = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_func)
                        pgsjt_pkg::FUNC_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        pgsjt_pkg::FUNC_LOAD: begin
                            if (!i_sts.full) begin
                                o_cmd.load = 1'b1;
                                n_state    = S_SORT;
                            end
                        end
                        pgsjt_pkg::FUNC_EMIT: begin
                            if (i_sts.empty || i_sts.done) begin
                                o_cmd.exhaust = 1'b1;
                            end else begin
                                o_cmd.emit_init = 1'b1;
                                n_state         = S_EMIT;
                            end
                        end
                        pgsjt_pkg::FUNC_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_sts.sort_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_sts.emit_last) begin
                    n_state = i_sts.fin ? S_IDLE : S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_emit_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && i_sts.emit_last && !i_sts.fin |=> (r_state == S_UPDATE))
        else $error("swap step skipped after a non-final permutation");
`endif

endmodule

// File: design/pgsjt_dp.sv
module pgsjt_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pgsjt_pkg::t_cmd                i_cmd,
    input  pgsjt_pkg::t_value              i_value,
    output pgsjt_pkg::t_status             o_sts,
    output logic                           o_strobe,
    output pgsjt_pkg::t_value              o_element,
    output logic [pgsjt_pkg::POS_W-1:0]    o_position,
    output logic                           o_last_of_perm,
    output logic                           o_final_perm,
    output logic                           o_exhausted
);

    localparam int N     = pgsjt_pkg::MAX_ELEMS;
    localparam int IDX_W = pgsjt_pkg::IDX_W;
    localparam int CNT_W = pgsjt_pkg::CNT_W;

    pgsjt_pkg::t_value r_elem [N];
    pgsjt_pkg::t_value n_elem [N];
    logic [N-1:0]      r_dir;
    logic [N-1:0]      n_dir;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_done;
    logic              n_done;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_fin;
    logic              n_fin;
    logic              r_found;
    logic              n_found;
    pgsjt_pkg::t_value r_best;
    pgsjt_pkg::t_value n_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic [IDX_W-1:0]  n_best_idx;
    logic              r_best_dir;
    logic              n_best_dir;

    logic                           r_strobe;
    pgsjt_pkg::t_value              r_element;
    logic [pgsjt_pkg::POS_W-1:0]    r_position;
    logic                           r_last;
    logic                           r_final;
    logic                           r_exh;

    logic [N-1:0]      used;
    logic [N-1:0]      mob;
    pgsjt_pkg::t_value cur;
    logic              emit_last;

    assign cur       = r_elem[r_idx];
    assign emit_last = ({{(CNT_W-IDX_W){1'b0}}, r_idx} + CNT_W'(1)) == r_count;

    // per-lane mobility against fixed neighbors
    always_comb begin
        for (int j = 0; j < N; j++) begin
            used[j] = CNT_W'(j) < r_count;
            mob[j]  = 1'b0;
            if (!r_dir[j]) begin
                if (j > 0) begin
                    mob[j] = used[j] && (r_elem[j-1] < r_elem[j]);
                end
            end else begin
                if (j + 1 < N) begin
                    mob[j] = (CNT_W'(j + 1) < r_count) && (r_elem[j+1] < r_elem[j]);
                end
            end
        end
    end

    always_comb begin
        pgsjt_pkg::t_value e;
        logic              d;
        logic              is_m;
        logic              is_t;
        e          = '0;
        d          = 1'b0;
        is_m       = 1'b0;
        is_t       = 1'b0;
        n_elem     = r_elem;
        n_dir      = r_dir;
        n_count    = r_count;
        n_done     = r_done;
        n_idx      = r_idx;
        n_fin      = r_fin;
        n_found    = r_found;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_best_dir = r_best_dir;

        if (i_cmd.clear) begin
            n_dir   = '0;
            n_count = '0;
            n_done  = 1'b0;
        end

        if (i_cmd.load) begin
            n_elem[r_count[IDX_W-1:0]] = i_value;
            n_count = r_count + CNT_W'(1);
            n_dir   = '0;
            n_done  = 1'b0;
            n_idx   = '0;
        end

        // odd-even transposition pass
        if (i_cmd.sort_step) begin
            for (int j = 0; j + 1 < N; j++) begin
                if ((j % 2) == int'(r_idx[0]) && CNT_W'(j + 1) < r_count &&
                    r_elem[j] > r_elem[j+1]) begin
                    n_elem[j]   = r_elem[j+1];
                    n_elem[j+1] = r_elem[j];
                end
            end
            n_idx = r_idx + IDX_W'(1);
        end

        if (i_cmd.emit_init) begin
            n_idx   = '0;
            n_found = 1'b0;
            n_fin   = ~|mob;
        end

        if (i_cmd.emit_step) begin
            if (mob[r_idx] && (!r_found || cur > r_best)) begin
                n_found    = 1'b1;
                n_best     = cur;
                n_best_idx = r_idx;
                n_best_dir = r_dir[r_idx];
            end
            n_idx = r_idx + IDX_W'(1);
            if (emit_last && r_fin) begin
                n_done = 1'b1;
            end
        end

        // swap the largest mobile element with its neighbor, flip larger ones
        if (i_cmd.update) begin
            for (int j = 0; j < N; j++) begin
                e    = r_elem[j];
                d    = r_dir[j];
                is_m = (IDX_W'(j) == r_best_idx);
                is_t = r_best_dir ? (IDX_W'(j) == r_best_idx + IDX_W'(1))
                                  : (IDX_W'(j) + IDX_W'(1) == r_best_idx);
                if (is_m) begin
                    if (r_best_dir) begin
                        if (j + 1 < N) begin
                            e = r_elem[j+1];
                            d = r_dir[j+1];
                        end
                    end else begin
                        if (j > 0) begin
                            e = r_elem[j-1];
                            d = r_dir[j-1];
                        end
                    end
                end else if (is_t) begin
                    e = r_best;
                    d = r_best_dir;
                end
                n_elem[j] = e;
                n_dir[j]  = d ^ (used[j] && (e > r_best));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_idx    <= '0;
            r_fin    <= 1'b0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_dir    <= n_dir;
            r_count  <= n_count;
            r_done   <= n_done;
            r_idx    <= n_idx;
            r_fin    <= n_fin;
            r_found  <= n_found;
            r_strobe <= i_cmd.emit_step | i_cmd.exhaust;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem     <= n_elem;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_dir <= n_best_dir;
        r_element  <= i_cmd.exhaust ? '0 : cur;
        r_position <= i_cmd.exhaust ? '0 : pgsjt_pkg::POS_W'(r_idx);
        r_last     <= i_cmd.exhaust | emit_last;
        r_final    <= ~i_cmd.exhaust & r_fin;
        r_exh      <= i_cmd.exhaust;
    end

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CNT_W'(N));
    assign o_sts.done      = r_done;
    assign o_sts.emit_last = emit_last;
    assign o_sts.sort_last = (r_idx == IDX_W'(N - 1));
    assign o_sts.fin       = r_fin;

    assign o_strobe       = r_strobe;
    assign o_element      = r_element;
    assign o_position     = r_position;
    assign o_last_of_perm = r_last;
    assign o_final_perm   = r_final;
    assign o_exhausted    = r_exh;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(N))
        else $error("element count beyond capacity");

    a_update_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> r_found)
        else $error("swap without a mobile element");

    a_final_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_exh && r_final && r_last |-> r_done)
        else $error("final permutation emitted but done not set");
`endif

endmodule
